[rtl/ucfc_pkg.sv]
package ucfc_pkg;

	localparam int MaxFrameBytesDef = 255;
	localparam int ArgBytesDef      = 32;

	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'h1021;
	localparam logic [15:0] CrcTop  = 16'h8000;

	localparam logic [7:0] ChComma = 8'h2C;

	typedef enum logic [1:0] {
		PH_BLANK,
		PH_DIGIT,
		PH_STOP
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_NO_COMMA    = 3'd1,
		ST_CRC_BAD     = 3'd2,
		ST_NO_TEAM     = 3'd3,
		ST_TEAM_BAD    = 3'd4,
		ST_NO_COMMAND  = 3'd5,
		ST_UNKNOWN_CMD = 3'd6
	} status_t;

	// Summary of one finished frame, handed from the parser to the emitter.
	typedef struct packed {
		status_t    status;
		logic [3:0] code;
		logic [4:0] alen;
		logic       bank;
	} frame_t;

	// Keywords, padded with zero bytes, first character in the top byte.
	localparam logic [39:0] KwText [12] = '{
		{"CX",    24'h0}, {"ST",    24'h0}, {"SIM",   16'h0}, {"SIMP",  8'h0},
		{"SIMG",  8'h0},  {"SIMI",  8'h0},  {"CAL",   16'h0}, {"ABORT"},
		{"CHUTE"},        {"RTL",   16'h0}, {"MAP",   16'h0}, {"OTA",   16'h0}
	};
	localparam logic [2:0] KwLen [12] = '{
		3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4, 3'd3, 3'd5, 3'd5, 3'd3, 3'd3, 3'd3
	};

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] c);
		logic [15:0] r;
		r = crc ^ {c, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if ((r & CrcTop) != 16'h0) r = (r << 1) ^ CrcPoly;
			else r = r << 1;
		end
		return r;
	endfunction

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	// Returns {valid, digit}.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= "0" && c <= "9") r = {1'b1, 4'(c - 8'h30)};
		else if (c >= "A" && c <= "F") r = {1'b1, 4'(c - 8'h37)};
		else if (c >= "a" && c <= "f") r = {1'b1, 4'(c - 8'h57)};
		return r;
	endfunction

	// Returns {hit, code}. Token lengths above five never match.
	function automatic logic [4:0] match_kw(input logic [39:0] chars, input logic [7:0] len);
		logic [4:0] r;
		logic [39:0] mask;
		r = '0;
		for (int k = 11; k >= 0; k--) begin
			mask = ~(40'hFF_FFFF_FFFF >> (8 * int'(KwLen[k])));
			if (len == {5'd0, KwLen[k]} && (chars & mask) == KwText[k])
				r = {1'b1, 4'(k)};
		end
		return r;
	endfunction

endpackage

[rtl/ucfc_parser.sv]
module ucfc_parser
	import ucfc_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MaxFrameBytesDef,
	parameter int ARG_BYTES       = ArgBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	input  logic [15:0] team_id_q,
	input  logic        emit_free,
	output logic        frame_done,
	output frame_t      frame,
	input  logic        rd_bank,
	input  logic [4:0]  rd_addr,
	output logic [7:0]  rd_data
);

	localparam int ArgCap = (ARG_BYTES - 1 < 31) ? ARG_BYTES - 1 : 31;
	localparam int IdxW   = (ArgCap > 1) ? $clog2(ArgCap) : 1;
	localparam logic [4:0] CapVal  = 5'(ArgCap);
	localparam logic [7:0] MaxVal  = 8'(MAX_FRAME_BYTES);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	logic [15:0] crc_q, crc_bc_q, hex_q;
	logic        comma_q, zero_q, bank_q;
	phase_t      hex_ph_q, team_ph_q;
	logic [7:0]  taken_q, tlen_q;
	logic [1:0]  tok_q;
	logic [16:0] team_q;
	logic [7:0]  kw_q [5];
	logic [4:0]  cnt_q;
	logic [7:0]  store0_q [ArgCap];
	logic [7:0]  store1_q [ArgCap];

	logic [15:0] crc_n, crc_bc_n, hex_n;
	logic        comma_n, zero_n;
	phase_t      hex_ph_n, team_ph_n;
	logic [7:0]  taken_n, tlen_n;
	logic [1:0]  tok_n;
	logic [16:0] team_n;
	logic [7:0]  kw_n [5];
	logic [4:0]  cnt_n;
	logic        wr_en;
	logic [20:0] team_mul;
	logic [4:0]  hd, kw_hit;
	logic        take, is_digit;

	assign advance  = valid_s1 && (!last_s1 || emit_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else if (!in_stall) valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		crc_n = crc_q; crc_bc_n = crc_bc_q; hex_n = hex_q;
		comma_n = comma_q; zero_n = zero_q;
		hex_ph_n = hex_ph_q; team_ph_n = team_ph_q;
		taken_n = taken_q; tlen_n = tlen_q; tok_n = tok_q;
		team_n = team_q; kw_n = kw_q; cnt_n = cnt_q;
		wr_en = 1'b0;
		hd = hex_digit(byte_s1);
		is_digit = byte_s1 >= "0" && byte_s1 <= "9";
		team_mul = {4'd0, team_q} * 21'd10 + {13'd0, byte_s1 - 8'h30};
		take = !zero_q && taken_q < MaxVal;
		if (take && byte_s1 == 8'h00) begin
			zero_n = 1'b1;
		end else if (take) begin
			taken_n = taken_q + 8'd1;
			crc_n = crc_byte(crc_q, byte_s1);
			if (byte_s1 == ChComma) begin
				crc_bc_n = crc_q;
				comma_n = 1'b1;
				hex_n = '0;
				hex_ph_n = PH_BLANK;
				if (tok_q == 2'd0 && tlen_q != 8'd0) begin
					tok_n = 2'd1;
					tlen_n = '0;
				end else if (tok_q == 2'd1 && tlen_q != 8'd0) begin
					tok_n = 2'd2;
				end else if (tok_q == 2'd2 && cnt_q != 5'd0) begin
					tok_n = 2'd3;
				end
			end else begin
				unique case (hex_ph_q)
					PH_BLANK: begin
						if (!is_blank(byte_s1)) begin
							if (!hd[4]) hex_ph_n = PH_STOP;
							else begin
								hex_n = {12'd0, hd[3:0]};
								hex_ph_n = PH_DIGIT;
							end
						end
					end
					PH_DIGIT: begin
						if (!hd[4]) hex_ph_n = PH_STOP;
						else hex_n = {hex_q[11:0], hd[3:0]};
					end
					default: ;
				endcase
				case (tok_q)
					2'd0: begin
						if (tlen_q != 8'hFF) tlen_n = tlen_q + 8'd1;
						if (team_ph_q == PH_STOP || (team_ph_q == PH_BLANK && is_blank(byte_s1)))
							team_ph_n = team_ph_q;
						else if (!is_digit) team_ph_n = PH_STOP;
						else begin
							team_ph_n = PH_DIGIT;
							team_n = (team_mul > 21'd65535) ? 17'h10000 : team_mul[16:0];
						end
					end
					2'd1: begin
						if (tlen_q < 8'd5) kw_n[tlen_q[2:0]] = byte_s1;
						if (tlen_q != 8'hFF) tlen_n = tlen_q + 8'd1;
					end
					2'd2: begin
						if (cnt_q < CapVal) begin
							wr_en = 1'b1;
							cnt_n = cnt_q + 5'd1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		kw_hit = match_kw({kw_n[0], kw_n[1], kw_n[2], kw_n[3], kw_n[4]}, tlen_n);
		frame.code = '0;
		frame.alen = '0;
		frame.bank = bank_q;
		if (!comma_n) frame.status = ST_NO_COMMA;
		else if (hex_n != crc_bc_n) frame.status = ST_CRC_BAD;
		else if (tok_n == 2'd0) frame.status = ST_NO_TEAM;
		else if (team_n != {1'b0, team_id_q}) frame.status = ST_TEAM_BAD;
		else if (tok_n == 2'd1) frame.status = ST_NO_COMMAND;
		else if (!kw_hit[4]) frame.status = ST_UNKNOWN_CMD;
		else begin
			frame.status = ST_OK;
			frame.code = kw_hit[3:0];
			if (tok_n == 2'd3) frame.alen = cnt_n;
		end
	end

	assign frame_done = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CrcInit; crc_bc_q <= '0; hex_q <= '0;
			comma_q <= 1'b0; zero_q <= 1'b0; bank_q <= 1'b0;
			hex_ph_q <= PH_BLANK; team_ph_q <= PH_BLANK;
			taken_q <= '0; tlen_q <= '0; tok_q <= '0; team_q <= '0;
			kw_q <= '{default: '0}; cnt_q <= '0;
		end else if (advance) begin
			if (last_s1) begin
				crc_q <= CrcInit; crc_bc_q <= '0; hex_q <= '0;
				comma_q <= 1'b0; zero_q <= 1'b0; bank_q <= !bank_q;
				hex_ph_q <= PH_BLANK; team_ph_q <= PH_BLANK;
				taken_q <= '0; tlen_q <= '0; tok_q <= '0; team_q <= '0;
				kw_q <= '{default: '0}; cnt_q <= '0;
			end else begin
				crc_q <= crc_n; crc_bc_q <= crc_bc_n; hex_q <= hex_n;
				comma_q <= comma_n; zero_q <= zero_n;
				hex_ph_q <= hex_ph_n; team_ph_q <= team_ph_n;
				taken_q <= taken_n; tlen_q <= tlen_n; tok_q <= tok_n; team_q <= team_n;
				kw_q <= kw_n; cnt_q <= cnt_n;
			end
		end
	end

	// Each bank is a small register file; the emitter picks one byte out of the idle bank.
	always_ff @(posedge clk) begin
		if (advance && wr_en && !bank_q) store0_q[cnt_q[IdxW-1:0]] <= byte_s1;
	end

	always_ff @(posedge clk) begin
		if (advance && wr_en && bank_q) store1_q[cnt_q[IdxW-1:0]] <= byte_s1;
	end

	assign rd_data = rd_bank ? store1_q[rd_addr[IdxW-1:0]] : store0_q[rd_addr[IdxW-1:0]];

endmodule

[rtl/ucfc_emitter.sv]
module ucfc_emitter
	import ucfc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       frame_done,
	input  frame_t     frame,
	output logic       emit_free,
	output logic       rd_bank,
	output logic [4:0] rd_addr,
	input  logic [7:0] rd_data,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       item_kind,
	output logic [2:0] status,
	output logic [3:0] command_code,
	output logic [4:0] argument_length,
	output logic [7:0] argument_byte,
	output logic       last_result
);

	logic   busy_q;
	logic [4:0] idx_q;
	frame_t fr_q;
	logic   step;

	assign step      = busy_q && !out_stall;
	assign emit_free = !busy_q || (step && idx_q == fr_q.alen);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (emit_free) begin
			busy_q <= frame_done;
			idx_q  <= '0;
		end else if (step) begin
			idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_free && frame_done) fr_q <= frame;
	end

	assign rd_bank         = fr_q.bank;
	assign rd_addr         = idx_q - 5'd1;
	assign out_valid       = busy_q;
	assign item_kind       = idx_q != 5'd0;
	assign status          = fr_q.status;
	assign command_code    = fr_q.code;
	assign argument_length = fr_q.alen;
	assign argument_byte   = (idx_q == 5'd0) ? 8'h00 : rd_data;
	assign last_result     = idx_q == fr_q.alen;

endmodule

[rtl/uplink_command_frame_checker.sv]
// The status header follows the last byte via the input register, then the emitter frame register.
// One byte per cycle enters unless in_stall is high; the header and each argument byte are items.
// The last byte of a frame waits only while the previous frame is still being emitted.
// Reset (arst_n low) clears frame state but not argument banks, zeroes team_id; no clearing pass.
module uplink_command_frame_checker
	import ucfc_pkg::*;
#(
	parameter int MAX_FRAME_BYTES = MaxFrameBytesDef,
	parameter int ARG_BYTES       = ArgBytesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] team_id,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        item_kind,
	output logic [2:0]  status,
	output logic [3:0]  command_code,
	output logic [4:0]  argument_length,
	output logic [7:0]  argument_byte,
	output logic        last_result
);

	// The team register takes a write in any cycle.
	logic [15:0] team_id_q;
	logic        frame_done, emit_free, rd_bank;
	logic [4:0]  rd_addr;
	logic [7:0]  rd_data;
	frame_t      frame;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) team_id_q <= '0;
		else if (cfg_valid) team_id_q <= team_id;
	end

	// The parser scans one registered byte per cycle unless stalled and writes the argument into one of
	// two banks, so the next frame can be parsed while the emitter reads the other bank.
	ucfc_parser #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES),
		.ARG_BYTES      (ARG_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.team_id_q (team_id_q),
		.emit_free (emit_free),
		.frame_done(frame_done),
		.frame     (frame),
		.rd_bank   (rd_bank),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data)
	);

	// The emitter holds the frame summary and steps through the header and argument bytes.
	ucfc_emitter u_emitter (
		.clk            (clk),
		.arst_n         (arst_n),
		.frame_done     (frame_done),
		.frame          (frame),
		.emit_free      (emit_free),
		.rd_bank        (rd_bank),
		.rd_addr        (rd_addr),
		.rd_data        (rd_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.status         (status),
		.command_code   (command_code),
		.argument_length(argument_length),
		.argument_byte  (argument_byte),
		.last_result    (last_result)
	);

endmodule
